// ===== design/cmac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmac_pkg
// Shared constants, types and helper functions of the circle and mask
// alpha compositor.
// ----------------------------------------------------------------------------
package cmac_pkg;

  // Mask atlas geometry
  localparam int MASK_SIZE  = 54;
  localparam int MASK_DEPTH = MASK_SIZE * MASK_SIZE;
  localparam int MASK_HALF  = MASK_SIZE / 2;
  localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
  localparam int MASK_CW    = (MASK_SIZE > 1) ? $clog2(MASK_SIZE) : 1;

  // Blend constants
  localparam logic [23:0] COLOR_WHITE = 24'hFF_FFFF;
  localparam logic [23:0] COLOR_SLATE = 24'h1E_2D41;
  localparam logic [7:0]  RING_GAIN   = 8'd230;
  localparam logic [7:0]  FILL_GAIN   = 8'd180;
  localparam logic [7:0]  MASK_GAIN   = 8'd245;
  localparam logic [7:0]  FULL_ALPHA  = 8'd255;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 13;

  localparam logic [12:0] FRAME_W_RST = 13'd640;
  localparam logic [12:0] FRAME_H_RST = 13'd480;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_RADIUS   = 3'd2,
    CFG_ALPHA    = 3'd3,
    CFG_FRAME_W  = 3'd4,
    CFG_FRAME_H  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0] center_x;   // two's complement
    logic [12:0] center_y;   // two's complement
    logic [9:0]  radius;
    logic [7:0]  alpha;
    logic [12:0] frame_w;
    logic [12:0] frame_h;
  } cfg_t;

  // Mask store access from the pipeline
  typedef struct packed {
    logic               we;
    logic [MASK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [MASK_AW-1:0] raddr;
  } ram_req_t;

  // floor(y / 255) for a 24-bit y. The shift-add estimate is at most one
  // short, so a single remainder check fixes it.
  function automatic logic [23:0] div255(input logic [23:0] y);
    logic [24:0] sum;
    logic [16:0] q;
    logic [25:0] rem;
    sum = {1'b0, y} + 25'(y >> 8) + 25'(y >> 16);
    q   = sum[24:8];
    rem = 26'(y) - (26'(q) << 8) + 26'(q);
    if (rem >= 26'd255) begin
      q = q + 17'd1;
    end
    return 24'(q);
  endfunction

endpackage

// ===== design/cmac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmac_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port and a read enable that holds the read data.
// ----------------------------------------------------------------------------
module cmac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cmac_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmac_pipe
// Seven-stage compositing pipeline: geometry, mask lookup, circle blend and
// mask blend. The whole pipe moves on adv_i.
// ----------------------------------------------------------------------------
module cmac_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                acc_i,
  input  logic                req_type_i,
  input  logic [11:0]         pixel_x_i,
  input  logic [11:0]         pixel_y_i,
  input  logic [31:0]         back_color_i,
  input  logic [11:0]         mask_index_i,
  input  logic [7:0]          mask_alpha_i,
  input  cmac_pkg::cfg_t      cfg_i,
  output cmac_pkg::ram_req_t  ram_o,
  input  logic [7:0]          ram_rdata_i,
  output logic                out_valid_o,
  output logic [11:0]         out_x_o,
  output logic [11:0]         out_y_o,
  output logic [31:0]         out_color_o
);

  localparam int NST = 7;

  // valid and coordinates travel through every stage
  logic [NST-1:0] v_q;
  logic [11:0]    x_q [NST];
  logic [11:0]    y_q [NST];

  // ---------------- stage 0: geometry and mask address --------------------
  logic [13:0] dx_d, dy_d;
  logic [12:0] adx_d, ady_d;
  logic [14:0] mx_d, my_d;
  logic        hit_d, en_d;

  always_comb begin
    dx_d  = {2'b00, pixel_x_i} - {cfg_i.center_x[12], cfg_i.center_x};
    dy_d  = {2'b00, pixel_y_i} - {cfg_i.center_y[12], cfg_i.center_y};
    adx_d = dx_d[13] ? 13'(-dx_d) : dx_d[12:0];
    ady_d = dy_d[13] ? 13'(-dy_d) : dy_d[12:0];
    mx_d  = {3'b000, pixel_x_i} - {{2{cfg_i.center_x[12]}}, cfg_i.center_x}
            + 15'(cmac_pkg::MASK_HALF);
    my_d  = {3'b000, pixel_y_i} - {{2{cfg_i.center_y[12]}}, cfg_i.center_y}
            + 15'(cmac_pkg::MASK_HALF);
    // sign bit clear means nonnegative; then unsigned compare is safe
    hit_d = !mx_d[14] && !my_d[14] && (mx_d < 15'(cmac_pkg::MASK_SIZE))
            && (my_d < 15'(cmac_pkg::MASK_SIZE));
    en_d  = (cfg_i.alpha != 8'd0) && (cfg_i.radius != 10'd0)
            && ({1'b0, pixel_x_i} < cfg_i.frame_w)
            && ({1'b0, pixel_y_i} < cfg_i.frame_h);

    ram_o.we    = acc_i && req_type_i
                  && (32'(mask_index_i) < 32'(cmac_pkg::MASK_DEPTH));
    ram_o.waddr = cmac_pkg::MASK_AW'(mask_index_i);
    ram_o.wdata = mask_alpha_i;
    ram_o.raddr = hit_d
      ? cmac_pkg::MASK_AW'(cmac_pkg::MASK_AW'(my_d[cmac_pkg::MASK_CW-1:0])
                           * cmac_pkg::MASK_AW'(cmac_pkg::MASK_SIZE)
                           + cmac_pkg::MASK_AW'(mx_d[cmac_pkg::MASK_CW-1:0]))
      : '0;
  end

  // stage 1 registers
  logic [31:0] s1_col_q;
  logic [12:0] s1_adx_q, s1_ady_q;
  logic        s1_hit_q, s1_en_q;

  // ---------------- stage 1: squares, mask times alpha --------------------
  logic [25:0] dx2_d, dy2_d;
  logic [19:0] r2_d, rm2_d;
  logic [9:0]  rm_d;
  logic [15:0] ma_d;

  always_comb begin
    dx2_d = 26'(s1_adx_q) * 26'(s1_adx_q);
    dy2_d = 26'(s1_ady_q) * 26'(s1_ady_q);
    r2_d  = 20'(cfg_i.radius) * 20'(cfg_i.radius);
    // |r - 2|: radius one squares to one
    rm_d  = (cfg_i.radius >= 10'd2) ? (cfg_i.radius - 10'd2) : (10'd2 - cfg_i.radius);
    rm2_d = 20'(rm_d) * 20'(rm_d);
    ma_d  = 16'(ram_rdata_i) * 16'(cfg_i.alpha);
  end

  logic [31:0] s2_col_q;
  logic [25:0] s2_dx2_q, s2_dy2_q;
  logic [19:0] s2_r2_q, s2_rm2_q;
  logic [15:0] s2_ma_q;
  logic        s2_hit_q, s2_en_q;

  // ---------------- stage 2: ring/fill decision, mask alpha step one ------
  logic [26:0] d2_d;
  logic        inside_d, ring_d;
  logic [7:0]  a_ring_d, a_fill_d, ca_d;
  logic [23:0] cfg_d;
  logic [15:0] q1_d;

  always_comb begin
    d2_d     = 27'(s2_dx2_q) + 27'(s2_dy2_q);
    inside_d = d2_d <= 27'(s2_r2_q);
    ring_d   = d2_d > 27'(s2_rm2_q);
    a_ring_d = 8'(cmac_pkg::div255(24'(cfg_i.alpha) * 24'(cmac_pkg::RING_GAIN)));
    a_fill_d = 8'(cmac_pkg::div255(24'(cfg_i.alpha) * 24'(cmac_pkg::FILL_GAIN)));
    ca_d     = !inside_d ? 8'd0 : (ring_d ? a_ring_d : a_fill_d);
    cfg_d    = ring_d ? cmac_pkg::COLOR_WHITE : cmac_pkg::COLOR_SLATE;
    q1_d     = 16'(cmac_pkg::div255(24'(s2_ma_q) * 24'(cmac_pkg::MASK_GAIN)));
  end

  logic [31:0] s3_col_q;
  logic [7:0]  s3_ca_q;
  logic [23:0] s3_fg_q;
  logic [15:0] s3_q1_q;
  logic        s3_hit_q, s3_en_q;

  // ---------------- stage 3: circle blend products, mask alpha step two ---
  logic [15:0] sum1_d [3];
  logic [7:0]  a3_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum1_d[c] = 16'(s3_col_q[8*c +: 8]) * 16'(cmac_pkg::FULL_ALPHA - s3_ca_q)
                + 16'(s3_fg_q[8*c +: 8]) * 16'(s3_ca_q);
    end
    a3_d = 8'(cmac_pkg::div255(24'(s3_q1_q)));
  end

  logic [31:0] s4_col_q;
  logic [15:0] s4_sum_q [3];
  logic        s4_apply_q;
  logic [7:0]  s4_a3_q;
  logic        s4_mh_q;

  // ---------------- stage 4: circle blend divide --------------------------
  logic [31:0] col1_d;

  always_comb begin
    if (s4_apply_q) begin
      col1_d[31:24] = 8'h00;
      for (int c = 0; c < 3; c++) begin
        col1_d[8*c +: 8] = 8'(cmac_pkg::div255(24'(s4_sum_q[c])));
      end
    end else begin
      col1_d = s4_col_q;
    end
  end

  logic [31:0] s5_col_q;
  logic [7:0]  s5_a3_q;
  logic        s5_mh_q;

  // ---------------- stage 5: mask blend products (toward white) -----------
  logic [15:0] sum2_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum2_d[c] = 16'(s5_col_q[8*c +: 8]) * 16'(cmac_pkg::FULL_ALPHA - s5_a3_q)
                + 16'(cmac_pkg::FULL_ALPHA) * 16'(s5_a3_q);
    end
  end

  logic [31:0] s6_col_q;
  logic [15:0] s6_sum_q [3];
  logic        s6_apply_q;

  // ---------------- stage 6: mask blend divide ----------------------------
  logic [31:0] col2_d;

  always_comb begin
    if (s6_apply_q) begin
      col2_d[31:24] = 8'h00;
      for (int c = 0; c < 3; c++) begin
        col2_d[8*c +: 8] = 8'(cmac_pkg::div255(24'(s6_sum_q[c])));
      end
    end else begin
      col2_d = s6_col_q;
    end
  end

  logic [31:0] out_col_q;

  // ---------------- registers ---------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NST-2:0], acc_i && !req_type_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0] <= pixel_x_i;
      y_q[0] <= pixel_y_i;
      for (int s = 1; s < NST; s++) begin
        x_q[s] <= x_q[s-1];
        y_q[s] <= y_q[s-1];
      end

      s1_col_q <= back_color_i;
      s1_adx_q <= adx_d;
      s1_ady_q <= ady_d;
      s1_hit_q <= hit_d;
      s1_en_q  <= en_d;

      s2_col_q <= s1_col_q;
      s2_dx2_q <= dx2_d;
      s2_dy2_q <= dy2_d;
      s2_r2_q  <= r2_d;
      s2_rm2_q <= rm2_d;
      s2_ma_q  <= ma_d;
      s2_hit_q <= s1_hit_q;
      s2_en_q  <= s1_en_q;

      s3_col_q <= s2_col_q;
      s3_ca_q  <= ca_d;
      s3_fg_q  <= cfg_d;
      s3_q1_q  <= q1_d;
      s3_hit_q <= s2_hit_q;
      s3_en_q  <= s2_en_q;

      s4_col_q   <= s3_col_q;
      s4_sum_q   <= sum1_d;
      s4_apply_q <= s3_en_q && (s3_ca_q != 8'd0);
      s4_a3_q    <= a3_d;
      s4_mh_q    <= s3_en_q && s3_hit_q;

      s5_col_q <= col1_d;
      s5_a3_q  <= s4_a3_q;
      s5_mh_q  <= s4_mh_q;

      s6_col_q   <= s5_col_q;
      s6_sum_q   <= sum2_d;
      // a nonzero mask alpha implies a nonzero mask entry
      s6_apply_q <= s5_mh_q && (s5_a3_q != 8'd0);

      out_col_q <= col2_d;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign out_x_o     = x_q[NST-1];
  assign out_y_o     = y_q[NST-1];
  assign out_color_o = out_col_q;

endmodule

// ===== design/circle_and_mask_alpha_compositor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_and_mask_alpha_compositor_top
// Composites a circle layer and an alpha-mask layer onto streamed pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per beat.
//   req_type_i = 0 composites the pixel at (pixel_x_i, pixel_y_i) over
//   back_color_i; req_type_i = 1 writes mask_alpha_i into the mask atlas at
//   mask_index_i and produces no result (indexes past the atlas are dropped).
//   Output channel (out_valid_o / out_stall_i) returns one result per pixel
//   request, in order, with the coordinates echoed.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the fully pipelined datapath and the single mask RAM that is
//   written and read in the acceptance cycle. A mask write is visible to any
//   pixel request accepted after it. When the receiver stalls a valid result,
//   the whole pipe holds and in_stall_o rises in the same cycle; bubbles are
//   not squeezed out. Configuration (cfg_we_i / cfg_addr_i / cfg_wdata_i) is
//   to be written by the user while the pipe is empty; the block does not
//   enforce this. Reset empties the pipe and loads the register defaults; the
//   mask atlas is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module circle_and_mask_alpha_compositor_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cmac_pkg::CFG_IW-1:0] cfg_addr_i,
  input  logic [cmac_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [11:0]                 pixel_x_i,
  input  logic [11:0]                 pixel_y_i,
  input  logic [31:0]                 back_color_i,
  input  logic [11:0]                 mask_index_i,
  input  logic [7:0]                  mask_alpha_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [11:0]                 out_x_o,
  output logic [11:0]                 out_y_o,
  output logic [31:0]                 out_color_o
);

  cmac_pkg::cfg_t     cfg_q;
  cmac_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;
  logic               adv, acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.radius   <= '0;
      cfg_q.alpha    <= '0;
      cfg_q.frame_w  <= cmac_pkg::FRAME_W_RST;
      cfg_q.frame_h  <= cmac_pkg::FRAME_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cmac_pkg::CFG_CENTER_X: cfg_q.center_x <= cfg_wdata_i;
        cmac_pkg::CFG_CENTER_Y: cfg_q.center_y <= cfg_wdata_i;
        cmac_pkg::CFG_RADIUS:   cfg_q.radius   <= cfg_wdata_i[9:0];
        cmac_pkg::CFG_ALPHA:    cfg_q.alpha    <= cfg_wdata_i[7:0];
        cmac_pkg::CFG_FRAME_W:  cfg_q.frame_w  <= cfg_wdata_i;
        cmac_pkg::CFG_FRAME_H:  cfg_q.frame_h  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the pipe moves whenever the output slot is free or being taken
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  cmac_ram #(
    .WIDTH (8),
    .DEPTH (cmac_pkg::MASK_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (adv),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  cmac_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .acc_i        (acc),
    .req_type_i   (req_type_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .back_color_i (back_color_i),
    .mask_index_i (mask_index_i),
    .mask_alpha_i (mask_alpha_i),
    .cfg_i        (cfg_q),
    .ram_o        (ram_req),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_color_o  (out_color_o)
  );

endmodule

// ===== design/cmac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmac_checker
// Port-level assertions for the compositor, bound to its top level.
// ----------------------------------------------------------------------------
module cmac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        req_type_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] out_x_o,
  input logic [11:0] out_y_o,
  input logic [31:0] out_color_o
);

  // stalled result holds its color
  a_out_hold_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_color_o))
    else $error("stalled result changed color");

  // stalled result holds its coordinates
  a_out_hold_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_x_o) && $stable(out_y_o))
    else $error("stalled result changed coordinates");

  // input backpressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a pixel request with a free-running receiver shows up at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !req_type_i) ##1 !out_stall_i ##1 !out_stall_i
    ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("pixel result missing at expected latency");

endmodule

bind circle_and_mask_alpha_compositor_top cmac_checker u_cmac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_color_o (out_color_o)
);

// ===== tb/tb_circle_and_mask_alpha_compositor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_and_mask_alpha_compositor_top
// Self-checking bench for the circle and mask alpha compositor. Every mask
// entry is written before the first pixel that reads it. A short directed part
// covers the ring and fill edges, the mask square corners, out-of-frame pixels,
// disabled drawing, radius one and extreme register values. Random phases
// follow, each with its own register setting, under three stall patterns.
// Every pixel result is compared with an in-order queue filled by a local
// predictor.
// ----------------------------------------------------------------------------
module tb_circle_and_mask_alpha_compositor_top;
  import cmac_pkg::*;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_MASK  = 1'b1;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 20;     // pipe is 7 deep
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 85;
  localparam int PRINT_CAP    = 100;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
  } pixel_t;

  // Predictor plus in-order store of expected pixels
  class compositor_scoreboard;
    int          cx, cy;
    int unsigned radius, alpha, fw, fh;
    logic [7:0]  atlas [MASK_DEPTH];
    bit          written [MASK_DEPTH];
    pixel_t      expected_q [$];
    int          mismatches;
    int          checked;
    int          mask_writes;

    function new();
      cx = 0;
      cy = 0;
      radius = 0;
      alpha = 0;
      fw = FRAME_W_RST;
      fh = FRAME_H_RST;
      mismatches = 0;
      checked = 0;
      mask_writes = 0;
      foreach (atlas[i]) atlas[i] = 8'd0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [12:0] v);
      case (idx)
        CFG_CENTER_X: cx = int'($signed(v));
        CFG_CENTER_Y: cy = int'($signed(v));
        CFG_RADIUS:   radius = v[9:0];
        CFG_ALPHA:    alpha = v[7:0];
        CFG_FRAME_W:  fw = v;
        CFG_FRAME_H:  fh = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] blend(logic [31:0] bg, logic [23:0] fg, int unsigned a);
      int unsigned inv, ch;
      logic [31:0] res;
      if (a == 0) return bg;
      inv = 255 - a;
      res = '0;
      for (int i = 0; i < 3; i++) begin
        ch = ((bg >> (8 * i)) & 32'hFF) * inv + ((fg >> (8 * i)) & 24'hFF) * a;
        res[8*i +: 8] = 8'(ch / 255);
      end
      return res;
    endfunction

    // atlas entry that a pixel reads under the current registers, or -1
    function int entry_for(logic [11:0] px, logic [11:0] py);
      longint mx, my;
      if (alpha == 0 || radius == 0 || px >= fw || py >= fh) return -1;
      mx = longint'(px) - (cx - MASK_HALF);
      my = longint'(py) - (cy - MASK_HALF);
      if (mx < 0 || mx >= MASK_SIZE || my < 0 || my >= MASK_SIZE) return -1;
      return int'(my * MASK_SIZE + mx);
    endfunction

    function void note_request(logic kind, logic [11:0] px, logic [11:0] py,
                               logic [31:0] bg, logic [11:0] idx, logic [7:0] mval);
      pixel_t  e;
      longint  dx, dy, d2, r, mx, my;
      int unsigned m;
      if (kind == REQ_MASK) begin
        mask_writes++;
        if (idx < MASK_DEPTH) begin
          atlas[idx] = mval;
          written[idx] = 1'b1;
        end
        return;
      end
      e.x = px;
      e.y = py;
      e.color = bg;
      if (alpha != 0 && radius != 0 && px < fw && py < fh) begin
        dx = longint'(px) - cx;
        dy = longint'(py) - cy;
        d2 = dx * dx + dy * dy;
        r  = radius;
        if (d2 <= r * r) begin
          if (d2 > (r - 2) * (r - 2))
            e.color = blend(e.color, COLOR_WHITE, alpha * RING_GAIN / 255);
          else
            e.color = blend(e.color, COLOR_SLATE, alpha * FILL_GAIN / 255);
        end
        mx = longint'(px) - (cx - MASK_HALF);
        my = longint'(py) - (cy - MASK_HALF);
        if (mx >= 0 && mx < MASK_SIZE && my >= 0 && my < MASK_SIZE) begin
          m = atlas[my * MASK_SIZE + mx];
          if (m != 0) e.color = blend(e.color, COLOR_WHITE, m * alpha * MASK_GAIN / 65025);
        end
      end
      expected_q.push_back(e);
    endfunction

    // one line per mismatch; printing stops after a cap, counting does not
    task report(string msg);
      if (mismatches < PRINT_CAP) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [11:0] x, logic [11:0] y, logic [31:0] color);
      pixel_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending x=%0d y=%0d color=%h", x, y, color));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (x !== e.x) report($sformatf("out_x %0d, expected %0d", x, e.x));
      if (y !== e.y) report($sformatf("out_y %0d, expected %0d", y, e.y));
      if (color !== e.color)
        report($sformatf("out_color %h, expected %h at (%0d,%0d)", color, e.color, e.x, e.y));
    endtask

    task check_empty();
      if (expected_q.size() != 0)
        report($sformatf("%0d pixel results never arrived", expected_q.size()));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]   cfg_addr_i = '0;
  logic [CFG_DW-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                req_type_i = REQ_PIXEL;
  logic [11:0]         pixel_x_i = '0;
  logic [11:0]         pixel_y_i = '0;
  logic [31:0]         back_color_i = '0;
  logic [11:0]         mask_index_i = '0;
  logic [7:0]          mask_alpha_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [11:0]         out_x_o;
  logic [11:0]         out_y_o;
  logic [31:0]         out_color_o;

  compositor_scoreboard sb = new();

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int cycles       = 0;
  int settings_cnt = 0;
  int cur_cx, cur_cy, cur_radius;

  circle_and_mask_alpha_compositor_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .back_color_i (back_color_i),
    .mask_index_i (mask_index_i),
    .mask_alpha_i (mask_alpha_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_color_o  (out_color_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i) cycles++;
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stall, results sampled at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_x_o, out_y_o, out_color_o);
  end

  // Entered and left at a falling edge. valid stays up after acceptance so
  // that a back-to-back request is a single assignment in that step.
  task automatic send_req(logic kind, logic [11:0] px, logic [11:0] py,
                          logic [31:0] bg, logic [11:0] idx, logic [7:0] mval);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    pixel_x_i    <= px;
    pixel_y_i    <= py;
    back_color_i <= bg;
    mask_index_i <= idx;
    mask_alpha_i <= mval;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(kind, px, py, bg, idx, mval);
    @(negedge clk_i);
  endtask

  task automatic mask_wr(int idx, int val);
    send_req(REQ_MASK, 12'($urandom), 12'($urandom), $urandom, 12'(idx), 8'(val));
  endtask

  task automatic pix(int x, int y, logic [31:0] bg);
    int e;
    // an atlas entry is written before the first pixel that reads it
    e = sb.entry_for(12'(x), 12'(y));
    if (e >= 0 && !sb.written[e])
      mask_wr(e, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
    send_req(REQ_PIXEL, 12'(x), 12'(y), bg, 12'($urandom), 8'($urandom));
  endtask

  // drop valid, wait for every pending result, then let the pipe run empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_regs(int cx, int cy, int r, int a, int fw, int fh);
    logic [12:0] vals [6];
    settle();
    vals[0] = 13'(cx);
    vals[1] = 13'(cy);
    vals[2] = 13'(r);
    vals[3] = 13'(a);
    vals[4] = 13'(fw);
    vals[5] = 13'(fh);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cx = int'($signed(vals[0]));
    cur_cy = int'($signed(vals[1]));
    cur_radius = r;
    settings_cnt++;
  endtask

  function automatic logic [11:0] near(int c, int off);
    int v;
    v = c + off;
    if (v < 0 || v > 4095) return 12'($urandom);
    return 12'(v);
  endfunction

  function automatic int pick_center();
    case ($urandom_range(0, 9))
      0: return -4096;
      1: return 4095;
      2: return int'($signed(13'($urandom)));
      default: return int'($urandom_range(0, 1200)) - 40;
    endcase
  endfunction

  function automatic int pick_frame();
    case ($urandom_range(0, 9))
      0: return 1;
      1, 2, 3: return $urandom_range(1, 4096);
      default: return 4096;
    endcase
  endfunction

  task automatic random_regs();
    int r, a;
    case ($urandom_range(0, 9))
      0: r = 0;
      1: r = 1;
      2: r = 2;
      3: r = 1023;
      4, 5: r = $urandom_range(0, 1023);
      default: r = $urandom_range(3, 60);
    endcase
    case ($urandom_range(0, 9))
      0: a = 0;
      1, 2: a = 255;
      default: a = $urandom_range(1, 255);
    endcase
    program_regs(pick_center(), pick_center(), r, a, pick_frame(), pick_frame());
  endtask

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    int sel, rr, dx, dy, rem;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      rr  = cur_radius;
      if (sel < 15) begin
        if ($urandom_range(0, 9) == 0) mask_wr($urandom_range(MASK_DEPTH, 4095), $urandom);
        else mask_wr($urandom_range(0, MASK_DEPTH - 1),
                     ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
      end else if (sel < 30) begin
        pix($urandom_range(0, 4095), $urandom_range(0, 4095), pick_color());
      end else if (sel < 55) begin
        // around the mask square, one pixel past each side
        dx = int'($urandom_range(0, 55)) - (MASK_HALF + 1);
        dy = int'($urandom_range(0, 55)) - (MASK_HALF + 1);
        pix(near(cur_cx, dx), near(cur_cy, dy), pick_color());
      end else if (sel < 80) begin
        // close to the outer edge of the circle
        dx  = int'($urandom_range(0, 2 * rr + 2)) - (rr + 1);
        rem = rr * rr - dx * dx;
        if (rem < 0) rem = 0;
        dy = int'($sqrt(real'(rem)));
        if ($urandom_range(0, 1)) dy = -dy;
        dy = dy + int'($urandom_range(0, 4)) - 2;
        pix(near(cur_cx, dx), near(cur_cy, dy), pick_color());
      end else begin
        dx = int'($urandom_range(0, 2 * rr + 6)) - (rr + 3);
        dy = int'($urandom_range(0, 2 * rr + 6)) - (rr + 3);
        pix(near(cur_cx, dx), near(cur_cy, dy), pick_color());
      end
    end
  endtask

  task automatic directed();
    program_regs(100, 80, 30, 255, 640, 480);
    mask_wr(0, 255);
    mask_wr(MASK_DEPTH - 1, 255);
    mask_wr(MASK_HALF * MASK_SIZE + MASK_HALF, 128);
    mask_wr(MASK_DEPTH, 77);            // past the atlas: dropped
    mask_wr(4095, 0);
    pix(100, 80, 32'h0000_0000);        // fill plus mask
    pix(130, 80, 32'hFFFF_FFFF);        // on the outer edge: ring
    pix(129, 80, 32'h1234_5678);        // ring
    pix(128, 80, 32'h1234_5678);        // exactly (r-2)^2: fill
    pix(131, 80, 32'hFFFF_FFFF);        // outside everything
    pix(127, 80, 32'h00AB_CDEF);        // inside circle, just past square
    pix(73, 53, 32'h8080_8080);         // square top-left corner
    pix(126, 106, 32'h8080_8080);       // square bottom-right corner
    pix(640, 80, 32'hDEAD_BEEF);        // past frame width
    pix(100, 480, 32'hDEAD_BEEF);       // past frame height
    pix(4095, 4095, 32'hFFFF_FFFF);
    program_regs(100, 80, 1, 255, 640, 480);
    pix(100, 80, 32'hFF00_FF00);        // radius one: fill only
    pix(101, 80, 32'hFF00_FF00);
    pix(101, 81, 32'hFF00_FF00);
    program_regs(100, 80, 30, 0, 640, 480);
    pix(100, 80, 32'hCAFE_F00D);        // alpha zero passes
    program_regs(100, 80, 0, 255, 640, 480);
    pix(100, 80, 32'hCAFE_F00D);        // radius zero passes
    program_regs(-4096, -4096, 1023, 255, 4096, 4096);
    pix(0, 0, 32'h0102_0304);
    pix(4095, 4095, 32'h0102_0304);
    program_regs(4095, 4095, 1023, 255, 1, 1);
    pix(0, 0, 32'hFFFF_FFFF);
    pix(1, 0, 32'hFFFF_FFFF);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_gap_pct = 7;
    stall_pct    = 74;
    directed();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p / (PHASES / 3))
        0: begin send_gap_pct = 7;  stall_pct = 74; end
        1: begin send_gap_pct = 74; stall_pct = 7;  end
        default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
      random_regs();
      random_phase(PHASE_ITEMS);
    end

    settle();
    sb.check_empty();
    $display("covered %0d pixel results and %0d mask writes over %0d register settings",
             sb.checked, sb.mask_writes, settings_cnt);
    $display("%0d mismatches in %0d cycles", sb.mismatches, cycles);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== circle_and_mask_alpha_compositor_top.f =====
design/cmac_pkg.sv
design/cmac_ram.sv
design/cmac_pipe.sv
design/circle_and_mask_alpha_compositor_top.sv
design/cmac_checker.sv
tb/tb_circle_and_mask_alpha_compositor_top.sv
